### rtl/differential_drive_odometry_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the differential-drive odometry block
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ODO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odometry check failed");

// antecedent implies consequent in the next cycle
`define ODO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odometry check failed");

`else

`define ODO_ASSERT_SAME(lbl, ante, cons)
`define ODO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared widths, reset values, CORDIC constants and control structs.
// ----------------------------------------------------------------------------
package odo_pkg;

  // field widths
  localparam int STEP_W    = 18;
  localparam int POSE_W    = 32;
  localparam int GAIN_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // CORDIC vector width (Q1.30 plus headroom) and table size
  localparam int CW          = 32;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W  = 5;
  localparam int CORDIC_ITERATIONS = 16;

  localparam logic signed [CW-1:0] CORDIC_START = 32'sd652032874;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 2'd3;

  // reset values
  localparam logic [GAIN_W-1:0] GAIN_RST    = 24'd13350400;
  localparam logic [POSE_W-1:0] HEADING_RST = 32'd536870912;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic angle;
    logic init;
    logic iter;
    logic mul_x;
    logic mul_y;
    logic add_y;
    logic load_out;
  } odo_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic iter_last;
  } odo_sts_t;

  // arctangent of 2^-i as binary angle, rounded
  function automatic logic [POSE_W-1:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
    logic [POSE_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10680862;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/odo_ctrl.sv
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer for one odometry update and owner of the output valid flag.
// ----------------------------------------------------------------------------
module odo_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  odo_pkg::odo_sts_t  sts,
  output odo_pkg::odo_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ANGLE = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_ITER  = 8'b0000_1000,
    S_MULX  = 8'b0001_0000,
    S_MULY  = 8'b0010_0000,
    S_ADDY  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // output register can take a new result
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_ANGLE;
        end
      end
      S_ANGLE: begin
        cmd.angle = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_last) state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_ADDY;
      end
      S_ADDY: begin
        cmd.add_y = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/odo_dp.sv
// ----------------------------------------------------------------------------
// odo_dp
// Pose registers, config registers, heading update, iterative CORDIC and
// the shared multiplier for the position update.
// ----------------------------------------------------------------------------
module odo_dp #(
  parameter int CORDIC_ITERATIONS = odo_pkg::CORDIC_ITERATIONS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  odo_pkg::odo_cmd_t                    cmd,
  output odo_pkg::odo_sts_t                    sts,
  input  logic                                 cfg_we,
  input  logic [odo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [odo_pkg::CFG_DAT_W-1:0]        cfg_wdata,
  input  logic signed [odo_pkg::STEP_W-1:0]    left_step,
  input  logic signed [odo_pkg::STEP_W-1:0]    right_step,
  input  logic                                 reload_pose,
  output logic signed [odo_pkg::POSE_W-1:0]    pos_x,
  output logic signed [odo_pkg::POSE_W-1:0]    pos_y,
  output logic [odo_pkg::POSE_W-1:0]           heading
);

  localparam int CNT_W  = $clog2(CORDIC_ITERATIONS);
  localparam int DIFF_W = odo_pkg::STEP_W + 1;
  localparam int GP_W   = DIFF_W + odo_pkg::GAIN_W + 1;
  localparam int MP_W   = odo_pkg::STEP_W + odo_pkg::CW;
  localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(CORDIC_ITERATIONS - 1);

  // config registers
  logic [odo_pkg::GAIN_W-1:0] gain_r;
  logic [odo_pkg::POSE_W-1:0] start_x_r, start_y_r, start_h_r;

  // pose state
  logic [odo_pkg::POSE_W-1:0] x_r, y_r, h_r;

  // per-item working registers
  logic signed [GP_W-1:0]             gprod_r;
  logic signed [odo_pkg::STEP_W-1:0]  d_r;
  logic signed [odo_pkg::CW-1:0]      cx_r, cy_r;
  logic [odo_pkg::POSE_W-1:0]         z_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic signed [MP_W-1:0]             mp_r;

  // output register
  logic [odo_pkg::POSE_W-1:0] ox_r, oy_r, oh_r;

  // combinational terms
  logic signed [DIFF_W-1:0]          diff_s, sum_s;
  logic signed [GP_W-1:0]            gprod_nxt, dth_full;
  logic signed [odo_pkg::CW-1:0]     dx, dy, mul_op;
  logic signed [MP_W-1:0]            mp_nxt, rnd_full;
  logic [odo_pkg::POSE_W-1:0]        atan_v;
  logic                              quad_flip;

  // heading change product and mean displacement
  assign diff_s    = $signed({right_step[odo_pkg::STEP_W-1], right_step})
                   - $signed({left_step[odo_pkg::STEP_W-1], left_step});
  assign sum_s     = $signed({right_step[odo_pkg::STEP_W-1], right_step})
                   + $signed({left_step[odo_pkg::STEP_W-1], left_step});
  assign gprod_nxt = diff_s * $signed({1'b0, gain_r});
  assign dth_full  = (gprod_r + GP_W'(128)) >>> 8;

  // CORDIC step terms
  assign quad_flip = h_r[odo_pkg::POSE_W-1] ^ h_r[odo_pkg::POSE_W-2];
  assign dx        = cy_r >>> cnt_r;
  assign dy        = cx_r >>> cnt_r;
  assign atan_v    = odo_pkg::atan_bam(odo_pkg::ATAN_IDX_W'(cnt_r));

  // shared multiplier and rounding of its registered product
  assign mul_op   = cmd.mul_y ? cy_r : cx_r;
  assign mp_nxt   = d_r * mul_op;
  assign rnd_full = (mp_r + MP_W'(536870912)) >>> 30;

  assign sts.iter_last = (cnt_r == ITER_LAST);

  assign pos_x   = $signed(ox_r);
  assign pos_y   = $signed(oy_r);
  assign heading = oh_r;

  // config registers and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= odo_pkg::GAIN_RST;
      start_x_r <= '0;
      start_y_r <= '0;
      start_h_r <= odo_pkg::HEADING_RST;
      x_r       <= '0;
      y_r       <= '0;
      h_r       <= odo_pkg::HEADING_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          odo_pkg::REG_ANGLE_GAIN:    gain_r    <= cfg_wdata[odo_pkg::GAIN_W-1:0];
          odo_pkg::REG_START_X:       start_x_r <= cfg_wdata;
          odo_pkg::REG_START_Y:       start_y_r <= cfg_wdata;
          odo_pkg::REG_START_HEADING: start_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.accept && reload_pose) begin
        x_r <= start_x_r;
        y_r <= start_y_r;
        h_r <= start_h_r;
      end
      if (cmd.angle) h_r <= h_r + dth_full[odo_pkg::POSE_W-1:0];
      if (cmd.mul_y) x_r <= x_r + rnd_full[odo_pkg::POSE_W-1:0];
      if (cmd.add_y) y_r <= y_r + rnd_full[odo_pkg::POSE_W-1:0];
    end
  end

  // working registers: capture, CORDIC rotation, multiplier
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      gprod_r <= gprod_nxt;
      d_r     <= sum_s[DIFF_W-1:1];
    end
    if (cmd.init) begin
      cx_r  <= quad_flip ? -odo_pkg::CORDIC_START : odo_pkg::CORDIC_START;
      cy_r  <= '0;
      z_r   <= quad_flip ? (h_r ^ 32'h8000_0000) : h_r;
      cnt_r <= '0;
    end
    if (cmd.iter) begin
      if (!z_r[odo_pkg::POSE_W-1]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - atan_v;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + atan_v;
      end
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.mul_x || cmd.mul_y) mp_r <= mp_nxt;
    if (cmd.load_out) begin
      ox_r <= x_r;
      oy_r <= y_r;
      oh_r <= h_r;
    end
  end

endmodule

### rtl/differential_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Dead-reckoning pose tracker for a two-wheel robot.
// ----------------------------------------------------------------------------
// Each input beat carries left and right wheel steps (Q1.16) and a reload
// flag; each one produces exactly one output beat with the updated x, y
// (Q15.16, wrapping) and binary-angle heading. Each item runs to completion
// before the next beat is accepted, its time set by the CORDIC, which does
// one rotation per cycle, plus one multiplier shared between the x and y
// products. A finished result sits in an output register, so the next beat
// is accepted while it waits; only the final load stalls if the previous
// result was not taken. Configuration is to be written by the user only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_top_macros.svh"

module differential_drive_odometry_top #(
  parameter int CORDIC_ITERATIONS = odo_pkg::CORDIC_ITERATIONS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,   // left_step, right_step, zero pad
  input  logic                              in_tuser,   // reload_pose
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [95:0]                       out_tdata,  // pos_x, pos_y, heading
  // configuration
  input  logic                              cfg_we,
  input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [odo_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  odo_pkg::odo_cmd_t cmd;
  odo_pkg::odo_sts_t sts;

  logic signed [odo_pkg::POSE_W-1:0] pos_x, pos_y;
  logic [odo_pkg::POSE_W-1:0]        heading;

  odo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  odo_dp #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .left_step   ($signed(in_tdata[17:0])),
    .right_step  ($signed(in_tdata[35:18])),
    .reload_pose (in_tuser),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading)
  );

  assign out_tdata = {heading, pos_y, pos_x};

  // checks
  `ODO_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `ODO_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_tvalid || out_tready)
  `ODO_ASSERT_SAME(a_one_command, 1'b1, $onehot0(cmd))

endmodule
